// File: hw/rtl/tpc_pkg.sv
`default_nettype none

package tpc_pkg;

    // position fields and canvas rows carry at most this many cells
    localparam int GRID_MAX      = 32;
    localparam int GRID_SIZE_DEF = 32;
    localparam int POS_W         = 5;
    localparam int ROW_W         = 32;

    typedef enum logic [2:0] {
        OP_PEN_UP   = 3'd0,
        OP_PEN_DOWN = 3'd1,
        OP_TURN_R   = 3'd2,
        OP_TURN_L   = 3'd3,
        OP_MOVE     = 3'd4,
        OP_READ     = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        STS_OK  = 2'd0,
        STS_OOB = 2'd1,
        STS_BAD = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        DIR_N = 2'd0,
        DIR_E = 2'd1,
        DIR_S = 2'd2,
        DIR_W = 2'd3
    } t_dir;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_INK,
        ST_READ
    } t_state;

    typedef struct packed {
        logic [2:0] opcode;
        logic [4:0] distance;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] x_pos;
        logic [POS_W-1:0] y_pos;
        logic [1:0]       heading;
        logic             pen_is_down;
        logic [POS_W-1:0] row_index;
        logic [ROW_W-1:0] row_bits;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        t_dir             dir;
        logic             down;
    } t_pen;

    // what a command does to the canvas: a rectangle of rows and a column mask
    typedef struct packed {
        t_status          status;
        logic             ink;
        logic [POS_W-1:0] row_lo;
        logic [POS_W-1:0] row_hi;
        logic [ROW_W-1:0] mask;
    } t_plan;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

    function automatic int grid_eff(input int g);
        return (g > GRID_MAX) ? GRID_MAX : g;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/turtle_plotter_canvas.sv
// turtle plotter over a square one-bit canvas of GRID_SIZE cells a side (at most 32)
// input channel: i_in_valid / o_in_ready carrying opcode and distance; one item is
// taken whenever the block is idle, even while a result still sits in the output
// register. output channel: o_out_valid / i_out_ready carrying the status, pen
// position, heading, pen state and, for a read, one canvas row with its index.
// pen, turn, invalid, rejected and pen-up moves: one result, loaded from EXEC once the output is free.
// pen-down move: the canvas rows it covers go through a read-modify-write on the
// row memory, one row a cycle pipelined; one result at the end.
// read canvas: one result per row, rows 0 upward, last set on the final row; the
// row memory read port gives one row a cycle while the receiver keeps up.
// the next item is taken the cycle after the previous command's final result is
// loaded into the output register.
// when the receiver stalls, the result holds in the output register and a read
// pauses with the next row held in the memory output register.
// reset (synchronous, active low): pen at column 0 row 0, heading south, pen up,
// canvas blank through per-row valid flags, so items are taken straight away.
`default_nettype none

module turtle_plotter_canvas import tpc_pkg::*; #(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    localparam int ROWS = grid_eff(GRID_SIZE);
    localparam int AW   = $clog2(ROWS);

    logic [2:0]      op;
    logic [4:0]      cmd_dist;
    logic            commit;
    t_pen            pen_cur;
    t_pen            pen_next;
    t_plan           plan;
    t_mem_ctl        mem_ctl;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic [ROWS-1:0] wr_data;
    logic [ROWS-1:0] rd_data;

    tpc_pen #(
        .GRID_SIZE (GRID_SIZE)
    ) u_pen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (op),
        .i_dist   (cmd_dist),
        .i_commit (commit),
        .o_cur    (pen_cur),
        .o_next   (pen_next),
        .o_plan   (plan)
    );

    tpc_canvas_mem #(
        .GRID_SIZE (GRID_SIZE)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    tpc_seq #(
        .GRID_SIZE (GRID_SIZE)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_op        (op),
        .o_dist      (cmd_dist),
        .o_commit    (commit),
        .i_cur       (pen_cur),
        .i_next      (pen_next),
        .i_plan      (plan),
        .o_mem_ctl   (mem_ctl),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .i_rd_data   (rd_data)
    );

`ifndef SYNTHESIS
    a_no_same_row_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_ctl.rd_en && mem_ctl.wr_en) |-> (rd_addr != wr_addr))
        else $error("canvas row read and written in the same cycle");

    a_pen_on_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.x_pos < ROWS) && (o_out_item.y_pos < ROWS))
        else $error("pen position off the grid");

    a_one_cmd_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("new item taken while a command is in progress");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != STS_OK)) |-> o_out_item.last)
        else $error("rejected command gave more than one result");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/tpc_canvas_mem.sv
`default_nettype none

module tpc_canvas_mem import tpc_pkg::*; #(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire t_mem_ctl                               i_ctl,
    input  wire logic [$clog2(grid_eff(GRID_SIZE))-1:0] i_rd_addr,
    input  wire logic [$clog2(grid_eff(GRID_SIZE))-1:0] i_wr_addr,
    input  wire logic [grid_eff(GRID_SIZE)-1:0]         i_wr_data,
    output logic      [grid_eff(GRID_SIZE)-1:0]         o_rd_data
);

    localparam int ROWS = grid_eff(GRID_SIZE);
    localparam int COLS = ROWS;

    logic [COLS-1:0] r_mem [ROWS];
    logic [ROWS-1:0] r_vld;
    logic [COLS-1:0] r_rd_data;
    logic            r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_vld  <= r_vld[i_rd_addr];
        end
    end

    // rows never written since reset read as blank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

// File: hw/rtl/tpc_pen.sv
`default_nettype none

module tpc_pen import tpc_pkg::*; #(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [2:0] i_op,
    input  wire logic [4:0] i_dist,
    input  wire logic       i_commit,
    output t_pen            o_cur,
    output t_pen            o_next,
    output t_plan           o_plan
);

    localparam int             GRID_EFF = grid_eff(GRID_SIZE);
    localparam logic [POS_W:0] LIM      = (POS_W+1)'(GRID_EFF - 1);

    t_pen             r_pen;
    t_pen             n_pen;
    logic [POS_W:0]   col_x;
    logic [POS_W:0]   row_x;
    logic [POS_W:0]   dist_x;
    logic [POS_W:0]   sum_col;
    logic [POS_W:0]   sum_row;
    logic             oob;
    logic [POS_W-1:0] new_col;
    logic [POS_W-1:0] new_row;
    logic [POS_W-1:0] col_lo;
    logic [POS_W-1:0] col_hi;
    logic [POS_W-1:0] row_lo;
    logic [POS_W-1:0] row_hi;
    t_status          sts;
    logic             ink;
    logic [ROW_W-1:0] mask;

    assign col_x   = {1'b0, r_pen.col};
    assign row_x   = {1'b0, r_pen.row};
    assign dist_x  = {1'b0, i_dist};
    assign sum_col = col_x + dist_x;
    assign sum_row = row_x + dist_x;

    // bounds check and end point of a move
    always_comb begin
        oob     = 1'b0;
        new_col = r_pen.col;
        new_row = r_pen.row;
        col_lo  = r_pen.col;
        col_hi  = r_pen.col;
        row_lo  = r_pen.row;
        row_hi  = r_pen.row;
        case (r_pen.dir)
            DIR_N: begin
                oob     = dist_x > row_x;
                new_row = POS_W'(row_x - dist_x);
                row_lo  = new_row;
            end
            DIR_E: begin
                oob     = sum_col > LIM;
                new_col = POS_W'(sum_col);
                col_hi  = new_col;
            end
            DIR_S: begin
                oob     = sum_row > LIM;
                new_row = POS_W'(sum_row);
                row_hi  = new_row;
            end
            DIR_W: begin
                oob     = dist_x > col_x;
                new_col = POS_W'(col_x - dist_x);
                col_lo  = new_col;
            end
            default: begin
                oob = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_pen = r_pen;
        sts   = STS_OK;
        case (i_op)
            OP_PEN_UP:   n_pen.down = 1'b0;
            OP_PEN_DOWN: n_pen.down = 1'b1;
            OP_TURN_R:   n_pen.dir  = t_dir'(2'(r_pen.dir + 2'd1));
            OP_TURN_L:   n_pen.dir  = t_dir'(2'(r_pen.dir + 2'd3));
            OP_MOVE: begin
                if (oob) begin
                    sts = STS_OOB;
                end else begin
                    n_pen.col = new_col;
                    n_pen.row = new_row;
                end
            end
            OP_READ: n_pen = r_pen;
            default: sts = STS_BAD;
        endcase
    end

    assign ink  = (i_op == OP_MOVE) && !oob && r_pen.down;
    assign mask = ({ROW_W{1'b1}} << col_lo)
                & ({ROW_W{1'b1}} >> (POS_W'(ROW_W - 1) - col_hi));

    assign o_plan = '{status: sts, ink: ink, row_lo: row_lo, row_hi: row_hi, mask: mask};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen.col  <= '0;
            r_pen.row  <= '0;
            r_pen.dir  <= DIR_S;
            r_pen.down <= 1'b0;
        end else if (i_commit) begin
            r_pen <= n_pen;
        end
    end

    assign o_cur  = r_pen;
    assign o_next = n_pen;

endmodule

`default_nettype wire

// File: hw/rtl/tpc_seq.sv
`default_nettype none

module tpc_seq import tpc_pkg::*; #(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire t_in_item                               i_in_item,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output t_out_item                                   o_out_item,
    output logic      [2:0]                             o_op,
    output logic      [4:0]                             o_dist,
    output logic                                        o_commit,
    input  wire t_pen                                   i_cur,
    input  wire t_pen                                   i_next,
    input  wire t_plan                                  i_plan,
    output t_mem_ctl                                    o_mem_ctl,
    output logic      [$clog2(grid_eff(GRID_SIZE))-1:0] o_rd_addr,
    output logic      [$clog2(grid_eff(GRID_SIZE))-1:0] o_wr_addr,
    output logic      [grid_eff(GRID_SIZE)-1:0]         o_wr_data,
    input  wire logic [grid_eff(GRID_SIZE)-1:0]         i_rd_data
);

    localparam int ROWS = grid_eff(GRID_SIZE);
    localparam int COLS = ROWS;
    localparam int AW   = $clog2(ROWS);

    t_state          r_state;
    t_state          n_state;
    logic [2:0]      r_op;
    logic [4:0]      r_dist;
    logic [AW-1:0]   r_row;
    logic [AW-1:0]   n_row;
    logic [AW-1:0]   r_row_end;
    logic [AW-1:0]   n_row_end;
    logic            r_more;
    logic            n_more;
    logic            r_rd_pend;
    logic            n_rd_pend;
    logic [AW-1:0]   r_rd_row;
    logic [AW-1:0]   n_rd_row;
    logic [COLS-1:0] r_mask;
    logic [COLS-1:0] n_mask;
    logic            r_out_valid;
    logic            n_out_valid;
    t_out_item       r_out;
    t_out_item       n_out;
    logic            out_free;
    logic            out_load;
    logic            rd_last;
    logic            accept;

    function automatic t_out_item make_result(input t_status sts, input t_pen pen,
                                              input logic [POS_W-1:0] ridx,
                                              input logic [ROW_W-1:0] rbits,
                                              input logic lst);
        t_out_item res;
        res.status      = sts;
        res.x_pos       = pen.col;
        res.y_pos       = pen.row;
        res.heading     = pen.dir;
        res.pen_is_down = pen.down;
        res.row_index   = ridx;
        res.row_bits    = rbits;
        res.last        = lst;
        return res;
    endfunction

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign rd_last    = (r_rd_row == AW'(ROWS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (r_op == OP_READ) begin
                    n_state = ST_READ;
                end else if (i_plan.ink) begin
                    n_state = ST_INK;
                end else if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_INK: begin
                if (!r_more && !r_rd_pend && out_free) n_state = ST_IDLE;
            end
            ST_READ: begin
                if (out_load && rd_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_mem_ctl = '0;
        o_commit  = 1'b0;
        out_load  = 1'b0;
        n_out     = r_out;
        n_row     = r_row;
        n_row_end = r_row_end;
        n_more    = r_more;
        n_mask    = r_mask;
        case (r_state)
            ST_EXEC: begin
                if (r_op == OP_READ) begin
                    n_row     = '0;
                    n_row_end = AW'(ROWS - 1);
                    n_more    = 1'b1;
                end else if (i_plan.ink) begin
                    // pen moves now, the rows are inked over the next cycles
                    o_commit  = 1'b1;
                    n_row     = AW'(i_plan.row_lo);
                    n_row_end = AW'(i_plan.row_hi);
                    n_mask    = COLS'(i_plan.mask);
                    n_more    = 1'b1;
                end else if (out_free) begin
                    o_commit = 1'b1;
                    out_load = 1'b1;
                    n_out    = make_result(i_plan.status, i_next, '0, '0, 1'b1);
                end
            end
            ST_INK: begin
                // read row r while row r-1 is written back
                o_mem_ctl.rd_en = r_more;
                o_mem_ctl.wr_en = r_rd_pend;
                if (!r_more && !r_rd_pend && out_free) begin
                    out_load = 1'b1;
                    n_out    = make_result(STS_OK, i_cur, '0, '0, 1'b1);
                end
            end
            ST_READ: begin
                // read data waits in the memory output until the result slot frees
                o_mem_ctl.rd_en = r_more && (!r_rd_pend || out_free);
                if (r_rd_pend && out_free) begin
                    out_load = 1'b1;
                    n_out    = make_result(STS_OK, i_cur, POS_W'(r_rd_row),
                                           ROW_W'(i_rd_data), rd_last);
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
        if (o_mem_ctl.rd_en) begin
            n_row  = AW'(r_row + 1'b1);
            n_more = (r_row != r_row_end);
        end
        n_rd_pend   = o_mem_ctl.rd_en
                    || (r_rd_pend && (r_state == ST_READ) && !out_load);
        n_rd_row    = o_mem_ctl.rd_en ? r_row : r_rd_row;
        n_out_valid = out_load || (r_out_valid && !i_out_ready);
    end

    assign o_rd_addr = r_row;
    assign o_wr_addr = r_rd_row;
    assign o_wr_data = i_rd_data | r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_more      <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_more      <= n_more;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_in_item.opcode;
            r_dist <= i_in_item.distance;
        end
        r_row     <= n_row;
        r_row_end <= n_row_end;
        r_rd_row  <= n_rd_row;
        r_mask    <= n_mask;
        r_out     <= n_out;
    end

    assign o_op        = r_op;
    assign o_dist      = r_dist;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire
